[src/phy_cr_pkg.sv]
// ============================================================================
// phy_cr_pkg
// Shared types and codes for the PHY control-register port master.
// ============================================================================
package phy_cr_pkg;

    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned DATA_W  = 16;
    localparam int unsigned CNT_W   = 17;
    localparam int unsigned PRE_W   = 8;
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned CFG_W   = 17;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] ACK_WAIT_LIMIT_RST  = CNT_W'(100000);
    localparam logic [PRE_W-1:0] PRE_CLOCK_COUNT_RST = PRE_W'(100);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_CLOCK_COUNT = 1'b1;

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_PRECLK = 2'd1,
        PH_ENABLE = 2'd2,
        PH_WAIT   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] req_addr;
        logic [DATA_W-1:0] req_wdata;
        logic              ack_in;
        logic [DATA_W-1:0] phy_rdata;
    } req_item_t;

    typedef struct packed {
        logic              cr_clk_pulse;
        logic              cr_select;
        logic [ADDR_W-1:0] cr_address;
        logic              cr_read_en;
        logic              cr_write_en;
        logic [DATA_W-1:0] cr_data_out;
        logic              busy_res;
        logic              done_res;
        logic              timed_out;
        logic [DATA_W-1:0] read_result;
    } res_item_t;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
    } cfg_wr_t;

endpackage

[src/phy_cr_in_reg.sv]
// ============================================================================
// phy_cr_in_reg
// Input register stage: capture one request item and hold it until taken.
// ============================================================================
module phy_cr_in_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  phy_cr_pkg::req_item_t in_item,
    output logic                  item_valid,
    output phy_cr_pkg::req_item_t item,
    input  logic                  item_take
);
    import phy_cr_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    req_item_t item_reg;

    // Accept whenever the stage is empty or drains this cycle
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[src/phy_cr_seq.sv]
// ============================================================================
// phy_cr_seq
// Access sequencer: state, configuration and one-period step logic.
// ============================================================================
module phy_cr_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  phy_cr_pkg::cfg_wr_t   cfg,
    input  logic                  step,
    input  phy_cr_pkg::req_item_t item,
    output phy_cr_pkg::res_item_t res
);
    import phy_cr_pkg::*;

    logic [CNT_W-1:0]  ack_wait_limit_reg;
    logic [PRE_W-1:0]  pre_clock_count_reg;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [DATA_W-1:0] wdata_reg, wdata_next;
    logic              is_write_reg, is_write_next;
    logic              select_reg, select_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_wait_limit_reg  <= ACK_WAIT_LIMIT_RST;
            pre_clock_count_reg <= PRE_CLOCK_COUNT_RST;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                CFG_ACK_WAIT_LIMIT:  ack_wait_limit_reg  <= cfg.data;
                CFG_PRE_CLOCK_COUNT: pre_clock_count_reg <= cfg.data[PRE_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        addr_next     = addr_reg;
        wdata_next    = wdata_reg;
        is_write_next = is_write_reg;
        select_next   = select_reg;
        res           = '0;

        case (phase_reg)
            PH_PRECLK:
            begin
                res.cr_clk_pulse = 1'b1;
                res.busy_res     = 1'b1;
                if (cnt_reg <= CNT_W'(1))
                begin
                    cnt_next   = '0;
                    phase_next = PH_ENABLE;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            PH_ENABLE:
            begin
                select_next      = 1'b1;
                res.cr_clk_pulse = 1'b1;
                res.busy_res     = 1'b1;
                res.cr_write_en  = is_write_reg;
                res.cr_read_en   = !is_write_reg;
                cnt_next         = ack_wait_limit_reg;
                phase_next       = PH_WAIT;
            end
            PH_WAIT:
            begin
                if (item.ack_in)
                begin
                    res.done_res = 1'b1;
                end
                else
                begin
                    res.cr_clk_pulse = 1'b1;
                    if (cnt_reg == '0)
                    begin
                        res.done_res  = 1'b1;
                        res.timed_out = 1'b1;
                    end
                    else
                    begin
                        cnt_next     = cnt_reg - CNT_W'(1);
                        res.busy_res = 1'b1;
                    end
                end
                if (res.done_res)
                begin
                    if (!is_write_reg)
                    begin
                        res.read_result = item.phy_rdata;
                    end
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                if (item.func == FUNC_READ || item.func == FUNC_WRITE)
                begin
                    res.busy_res  = 1'b1;
                    addr_next     = item.req_addr;
                    is_write_next = (item.func == FUNC_WRITE);
                    if (item.func == FUNC_WRITE)
                    begin
                        wdata_next = item.req_wdata;
                    end
                    cnt_next   = CNT_W'(pre_clock_count_reg);
                    phase_next = (pre_clock_count_reg == '0) ? PH_ENABLE : PH_PRECLK;
                end
            end
        endcase

        res.cr_select   = select_next;
        res.cr_address  = addr_next;
        res.cr_data_out = wdata_next;
    end

    // Advance state once per consumed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            cnt_reg      <= '0;
            addr_reg     <= '0;
            wdata_reg    <= '0;
            is_write_reg <= 1'b0;
            select_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            addr_reg     <= addr_next;
            wdata_reg    <= wdata_next;
            is_write_reg <= is_write_next;
            select_reg   <= select_next;
        end
    end

endmodule

[src/phy_cr_port_master.sv]
// ============================================================================
// phy_cr_port_master
// Master for a PHY control-register port, one port clock period per request.
// ============================================================================
//
//  channel   handshake            payload
//  --------  -------------------  ------------------------------------------
//  input     in_valid / in_ready  func, req_addr, req_wdata, ack_in, phy_rdata
//  output    out_valid/out_ready  cr_* lines, busy_res, done_res, timed_out,
//                                 read_result
//  config    cfg_we (no wait)     cfg_index, cfg_data
//
//  Each request passes through the input register and then the result
//  register, and one request is taken every cycle unless the output stalls.
//  The step logic between the two registers (one 17-bit decrement and
//  compare) sets the clock period.
//  Reset clears the handshake valids, the sequencer state and the
//  configuration to its default values.
//  A stalled output holds its result; the input register keeps accepting
//  while the result register is free or drains in the same cycle.
//
module phy_cr_port_master (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [phy_cr_pkg::FUNC_W-1:0]     func,
    input  logic [phy_cr_pkg::ADDR_W-1:0]     req_addr,
    input  logic [phy_cr_pkg::DATA_W-1:0]     req_wdata,
    input  logic                              ack_in,
    input  logic [phy_cr_pkg::DATA_W-1:0]     phy_rdata,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              cr_clk_pulse,
    output logic                              cr_select,
    output logic [phy_cr_pkg::ADDR_W-1:0]     cr_address,
    output logic                              cr_read_en,
    output logic                              cr_write_en,
    output logic [phy_cr_pkg::DATA_W-1:0]     cr_data_out,
    output logic                              busy_res,
    output logic                              done_res,
    output logic                              timed_out,
    output logic [phy_cr_pkg::DATA_W-1:0]     read_result,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [phy_cr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [phy_cr_pkg::CFG_W-1:0]      cfg_data
);
    import phy_cr_pkg::*;

    req_item_t in_item;
    req_item_t item;
    logic      item_valid;
    logic      item_take;
    res_item_t res;
    res_item_t res_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    cfg_wr_t   cfg;

    assign in_item.func      = func;
    assign in_item.req_addr  = req_addr;
    assign in_item.req_wdata = req_wdata;
    assign in_item.ack_in    = ack_in;
    assign in_item.phy_rdata = phy_rdata;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    phy_cr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // Advance the held request into the result register when it has room;
    // the sequencer state steps in the same cycle.
    assign item_take = item_valid && (!out_valid_reg || out_ready);

    phy_cr_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (item_take),
        .item  (item),
        .res   (res)
    );

    assign out_valid_next = item_take || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cr_clk_pulse = res_reg.cr_clk_pulse;
    assign cr_select    = res_reg.cr_select;
    assign cr_address   = res_reg.cr_address;
    assign cr_read_en   = res_reg.cr_read_en;
    assign cr_write_en  = res_reg.cr_write_en;
    assign cr_data_out  = res_reg.cr_data_out;
    assign busy_res     = res_reg.busy_res;
    assign done_res     = res_reg.done_res;
    assign timed_out    = res_reg.timed_out;
    assign read_result  = res_reg.read_result;

endmodule
